FILE: rtl/assert_macros.svh
// assertion macros for use in the rtl
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define LQS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define LQS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/lqs_pkg.sv
// shared types and codes for the linear queue with search
// no dependencies
`default_nettype none

package lqs_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SLOT_W   = 7;

  localparam logic [OPCODE_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FIND = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN,
    S_DONE
  } lqs_state_t;

endpackage

`default_nettype wire

FILE: rtl/linear_queue_with_search.sv
// linear queue with search: top level, slot memory and sequencer
// depends on lqs_pkg and assert_macros.svh
`default_nettype none

// Linear (non-circular) queue of DEPTH signed 32-bit words with enqueue,
// dequeue and search. One request is worked at a time; req_stall is high from
// acceptance until the answer has been moved to the output register. Enqueue,
// unused opcodes and empty-queue requests go from idle straight to the done
// state, dequeues pass the dequeue state, and a search compares n slots (1 to
// DEPTH) in the scan state, since the scan goes through the single read port
// of the slot memory one word per cycle into one shared comparator. The
// output register lets the block accept the next request while the previous
// answer still waits on rsp_stall. Slots need no clearing after reset.
module linear_queue_with_search #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic [lqs_pkg::OPCODE_W-1:0]  opcode,
  input  wire logic signed [lqs_pkg::WORD_W-1:0] value,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output logic [lqs_pkg::STATUS_W-1:0]       status,
  output logic signed [lqs_pkg::WORD_W-1:0]  removed_value,
  output logic [lqs_pkg::SLOT_W-1:0]         found_slot
);
  import lqs_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  lqs_state_t state, state_next;

  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic          is_empty, is_empty_next;
  logic [IW-1:0] idx, idx_next;
  logic [WORD_W-1:0] key, key_next;

  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [WORD_W-1:0]   res_removed, res_removed_next;
  logic [SLOT_W-1:0]   res_found, res_found_next;

  logic rsp_load;
  logic rsp_valid_next;

  logic [WORD_W-1:0] slots [DEPTH];
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [IW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slots[mem_waddr] <= mem_wdata;
    end
    rd_data <= slots[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      is_empty  <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      is_empty  <= is_empty_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    key         <= key_next;
    res_status  <= res_status_next;
    res_removed <= res_removed_next;
    res_found   <= res_found_next;
    if (rsp_load) begin
      status        <= res_status;
      removed_value <= res_removed;
      found_slot    <= res_found;
    end
  end

  always_comb begin
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    is_empty_next    = is_empty;
    idx_next         = idx;
    key_next         = key;
    res_status_next  = res_status;
    res_removed_next = res_removed;
    res_found_next   = res_found;
    mem_we           = 1'b0;
    mem_waddr        = tail + 1'b1;
    mem_wdata        = value;
    rd_addr          = idx;
    rsp_load         = 1'b0;

    unique case (state)
      S_IDLE: begin
        // head word is read on acceptance, ready for dequeue or the first compare
        rd_addr = head;
        if (req_valid) begin
          key_next         = value;
          res_status_next  = ST_OK;
          res_removed_next = '0;
          res_found_next   = '0;
          state_next       = S_DONE;
          unique case (opcode)
            OP_ENQ: begin
              if (is_empty) begin
                head_next     = '0;
                tail_next     = '0;
                is_empty_next = 1'b0;
                mem_we        = 1'b1;
                mem_waddr     = '0;
              end else if (tail == LAST) begin
                res_status_next = ST_FULL;
              end else begin
                tail_next = tail + 1'b1;
                mem_we    = 1'b1;
              end
            end
            OP_DEQ: begin
              if (is_empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                state_next = S_DEQ;
              end
            end
            OP_FIND: begin
              if (is_empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                idx_next   = head;
                state_next = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEQ: begin
        res_removed_next = rd_data;
        if (head == tail) begin
          head_next     = '0;
          tail_next     = '0;
          is_empty_next = 1'b1;
        end else begin
          head_next = head + 1'b1;
        end
        state_next = S_DONE;
      end
      S_SCAN: begin
        // rd_data holds slots[idx]; fetch the following slot meanwhile
        rd_addr = idx + 1'b1;
        if (rd_data == key) begin
          res_found_next = SLOT_W'(idx);
          state_next     = S_DONE;
        end else if (idx == tail) begin
          res_status_next = ST_MISS;
          state_next      = S_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rsp_valid_next = rsp_load || (rsp_valid && rsp_stall);
  assign req_stall      = (state != S_IDLE);

`include "assert_macros.svh"

  `LQS_ASSERT(a_order, !is_empty |-> head <= tail, "head past tail in a non-empty queue")
  `LQS_ASSERT(a_empty_idx, is_empty |-> (head == '0 && tail == '0), "empty queue with nonzero index")
  `LQS_ASSERT(a_scan_range, state == S_SCAN |-> (idx >= head && idx <= tail), "scan outside queue")
  `LQS_ASSERT(a_enq_step,
    (req_valid && !req_stall && opcode == OP_ENQ && !is_empty && tail != LAST)
      |=> tail == $past(tail) + 1'b1, "enqueue did not advance tail")
  `LQS_ASSERT(a_miss_slot, (state == S_DONE && res_status != ST_OK) |-> res_found == '0,
    "slot reported with a failing status")

endmodule

`default_nettype wire

FILE: dv/linear_queue_with_search_tb.sv
// testbench for linear_queue_with_search: directed and random enqueue, dequeue
// and search traffic checked against a behavioral mirror of the queue
// depends on lqs_pkg and the linear_queue_with_search rtl
`timescale 1ns / 100ps

module linear_queue_with_search_tb;
  import lqs_pkg::*;

  localparam int unsigned DEPTH = 128;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] removed;
    logic [SLOT_W-1:0]        slot;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [OPCODE_W-1:0] opcode = OP_ENQ;
  logic signed [WORD_W-1:0] value = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic signed [WORD_W-1:0] removed_value;
  logic [SLOT_W-1:0] found_slot;

  // mirror of the queue contents
  logic signed [WORD_W-1:0] mirror_slots [DEPTH];
  int unsigned mirror_head = 0;
  int unsigned mirror_tail = 0;
  bit mirror_empty = 1'b1;

  answer_t pending_answers [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  linear_queue_with_search #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .opcode(opcode),
    .value(value),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status(status),
    .removed_value(removed_value),
    .found_slot(found_slot)
  );

  always #1 clk = ~clk;

  // applies one request to the mirror and returns the answer it should get
  function automatic answer_t queue_answer(input logic [OPCODE_W-1:0] op,
                                           input logic signed [WORD_W-1:0] val);
    answer_t a;
    int unsigned i;
    a = '0;
    a.status = ST_OK;
    case (op)
      OP_ENQ: begin
        if (mirror_empty) begin
          mirror_head = 0;
          mirror_tail = 0;
          mirror_empty = 1'b0;
          mirror_slots[0] = val;
        end else if (mirror_tail >= DEPTH - 1) begin
          a.status = ST_FULL;
        end else begin
          mirror_tail++;
          mirror_slots[mirror_tail] = val;
        end
      end
      OP_DEQ: begin
        if (mirror_empty) begin
          a.status = ST_EMPTY;
        end else begin
          a.removed = mirror_slots[mirror_head];
          if (mirror_head == mirror_tail) begin
            mirror_head = 0;
            mirror_tail = 0;
            mirror_empty = 1'b1;
          end else begin
            mirror_head++;
          end
        end
      end
      OP_FIND: begin
        if (mirror_empty) begin
          a.status = ST_EMPTY;
        end else begin
          a.status = ST_MISS;
          for (i = mirror_head; i <= mirror_tail; i++) begin
            if (mirror_slots[i] == val) begin
              a.status = ST_OK;
              a.slot = SLOT_W'(i);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // word mix: extremes, a small pool that repeats, and fully random words
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return WORD_W'($urandom_range(7)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // search key: mostly a word currently held, otherwise anything
  function automatic logic signed [WORD_W-1:0] pick_key();
    if (!mirror_empty && $urandom_range(99) < 70)
      return mirror_slots[$urandom_range(mirror_tail, mirror_head)];
    return pick_word();
  endfunction

  // entered and left at a falling edge
  task automatic send_word(input logic [OPCODE_W-1:0] op,
                           input logic signed [WORD_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    opcode <= op;
    value <= val;
    do @(posedge clk); while (req_stall);
    pending_answers.push_back(queue_answer(op, val));
    @(negedge clk);
  endtask

  task automatic note_mismatch(input answer_t want, input answer_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch: expected status %0d removed %0d slot %0d, got status %0d removed %0d slot %0d",
               want.status, want.removed, want.slot, got.status, got.removed, got.slot);
  endtask

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin : check_answers
    answer_t got;
    answer_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      got.status = status;
      got.removed = removed_value;
      got.slot = found_slot;
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected word: status %0d removed %0d slot %0d",
                   got.status, got.removed, got.slot);
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status || got.removed !== want.removed ||
            got.slot !== want.slot)
          note_mismatch(want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // requests against an empty queue, including the unused opcode
  task automatic test_empty_queue();
    send_word(OP_DEQ, 32'sh0);
    send_word(OP_FIND, 32'sh0);
    send_word(OP_UNUSED, 32'shffff_ffff);
  endtask

  task automatic test_basic_ops();
    send_word(OP_ENQ, 32'sh8000_0000);
    send_word(OP_ENQ, 32'sh7fff_ffff);
    send_word(OP_ENQ, 32'sh0);
    send_word(OP_ENQ, -32'sd1);
    send_word(OP_ENQ, 32'sd1);
    send_word(OP_FIND, 32'sh8000_0000);
    send_word(OP_FIND, -32'sd1);
    send_word(OP_FIND, 32'sd12345);
    send_word(OP_UNUSED, 32'sh5555_aaaa);
    send_word(OP_DEQ, 32'shffff_ffff);
    // the old head is no longer in range of the scan
    send_word(OP_FIND, 32'sh8000_0000);
    repeat (4) send_word(OP_DEQ, 32'sh0);
    send_word(OP_DEQ, 32'sh0);
    // refill after emptying goes back to slot 0
    send_word(OP_ENQ, 32'sd5);
    send_word(OP_FIND, 32'sd5);
    send_word(OP_ENQ, 32'sd7);
    send_word(OP_ENQ, 32'sd7);
    send_word(OP_FIND, 32'sd7);
  endtask

  // fill to the last slot; full stays until the queue drains completely
  task automatic test_full_queue();
    int unsigned i;
    while (!mirror_empty) send_word(OP_DEQ, $urandom);
    for (i = 0; i < DEPTH; i++) send_word(OP_ENQ, $urandom);
    send_word(OP_ENQ, $urandom);
    send_word(OP_ENQ, 32'sh7fff_ffff);
    repeat (3) send_word(OP_DEQ, $urandom);
    send_word(OP_ENQ, $urandom);
    send_word(OP_FIND, mirror_slots[mirror_tail]);
    send_word(OP_FIND, mirror_slots[mirror_head]);
    send_word(OP_FIND, mirror_slots[0]);
    while (!mirror_empty) send_word(OP_DEQ, $urandom);
    send_word(OP_DEQ, $urandom);
  endtask

  // alternating fill and drain runs with searches and unused opcodes mixed in
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned done_items;
    int unsigned r;
    bit draining;
    done_items = 0;
    draining = 1'b0;
    while (done_items < n_items) begin
      if (mirror_empty)
        draining = 1'b0;
      else if (!draining && (mirror_tail == DEPTH - 1 || $urandom_range(99) < 2))
        draining = 1'b1;
      r = $urandom_range(99);
      if (r < 4) begin
        send_word(OP_UNUSED, $urandom);
      end else begin
        if (r < (draining ? 19 : 59))
          send_word(OP_ENQ, pick_word());
        else if (r < (draining ? 64 : 74))
          send_word(OP_DEQ, $urandom);
        else
          send_word(OP_FIND, pick_key());
        done_items++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 24;
    recv_idle_pct = 68;
    test_empty_queue();
    test_basic_ops();
    test_full_queue();
    test_random_traffic(400);

    send_idle_pct = 68;
    recv_idle_pct = 24;
    test_random_traffic(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(400);

    req_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
